FILE: src/assert_macros.svh
// Assertion macros shared by the pool allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/pfl_pkg.sv
// Package with types, codes and the address function of the pool allocator.
package pfl_pkg;

    localparam int ID_W      = 7;
    localparam int SLOTS_DEF = 64;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_ENUM  = 3'd3;
    localparam logic [2:0] OP_REF   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD_ID  = 2'd2;
    localparam logic [1:0] ST_NO_LIVE = 2'd3;

    localparam logic [1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [1:0] CFG_SLOT_BYTES = 2'd1;
    localparam logic [1:0] CFG_BASE_ADDR  = 2'd2;

    typedef struct packed {
        logic [2:0]      operation;
        logic [ID_W-1:0] slot_id;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] result_id;
        logic [31:0]     slot_address;
        logic            last;
    } rsp_t;

    // Access controls for the link and mark stores; addresses are zero-based slot indexes.
    typedef struct packed {
        logic            link_we;
        logic [ID_W-1:0] link_waddr;
        logic [ID_W-1:0] link_wdata;
        logic            link_re;
        logic [ID_W-1:0] link_raddr;
        logic            mark_we;
        logic [ID_W-1:0] mark_waddr;
        logic            mark_wdata;
        logic            mark_re;
        logic [ID_W-1:0] mark_raddr;
    } mem_req_t;

    // Byte address of a slot: base + (id - 1) * size rounded up to eight, wrapping at 32 bits.
    function automatic logic [31:0] slot_addr_f(input logic [31:0] base,
                                                input logic [12:0] bytes,
                                                input logic [ID_W-1:0] id);
        logic [13:0]     sz;
        logic [ID_W-1:0] idm;
        logic [20:0]     prod;
        sz   = ({1'b0, bytes} + 14'd7) & ~14'd7;
        idm  = id - ID_W'(1);
        prod = 21'(idm) * 21'(sz);
        return base + {11'd0, prod};
    endfunction

endpackage

FILE: src/pfl_store.sv
// Link and mark memories of the pool allocator, registered reads.
module pfl_store #(
    parameter int SLOTS = pfl_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  pfl_pkg::mem_req_t        req,
    output logic [pfl_pkg::ID_W-1:0] link_rd,
    output logic                     mark_rd
);
    import pfl_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ID_W-1:0] link_mem [SLOTS];
    logic            mark_mem [SLOTS];

    // Read-before-write: a read and a write at one address return the old entry.
    always_ff @(posedge clk)
    begin
        if (req.link_we)
        begin
            link_mem[req.link_waddr[IDX_W-1:0]] <= req.link_wdata;
        end
        if (req.link_re)
        begin
            link_rd <= link_mem[req.link_raddr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.mark_we)
        begin
            mark_mem[req.mark_waddr[IDX_W-1:0]] <= req.mark_wdata;
        end
        if (req.mark_re)
        begin
            mark_rd <= mark_mem[req.mark_raddr[IDX_W-1:0]];
        end
    end

endmodule

FILE: src/pool_free_list_allocator_core.sv
// Top level of the fixed-size pool allocator with a linked free list.
// Usage:
//   cfg channel: write slot_count (index 0), slot_bytes (1) or base_address (2) while idle;
//     cfg_ready is high only while the sequencer is idle, other indexes are dropped.
//   req channel: one transaction per operation (init, alloc, free, enumerate, reference).
//   rsp channel: one transaction per result; last marks the final result of a request.
// Flow:
//   alloc, free, reference, unknown ops: S_ONE forms the result and registers it in
//     the output stage; the head link read for alloc is started while idle.
//   init: one link-store entry rewritten per cycle over all SLOTS entries.
//   enumerate: one free-list step per S_WALK and S_WALK_WAIT pass (link read), then
//     one S_SCAN and S_SCAN_CHK pass per slot scanned in 1..n, then S_SCAN_END; output
//     stalls can hold the sequencer.
// Reset: the block runs the init sweep over all SLOTS entries with
//   req_ready and cfg_ready low. No result is produced.
// Stall: a result waits in the output register while rsp_ready is low; a new
//   request is accepted meanwhile, and the sequencer holds when it has the next
//   result ready and the output register is still full.
`include "assert_macros.svh"

module pool_free_list_allocator_core #(
    parameter int SLOTS = pfl_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          req_valid,
    output logic          req_ready,
    input  pfl_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pfl_pkg::rsp_t rsp_data
);
    import pfl_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_INIT      = 8'b0000_0010,
        S_ONE       = 8'b0000_0100,
        S_WALK      = 8'b0000_1000,
        S_WALK_WAIT = 8'b0001_0000,
        S_SCAN      = 8'b0010_0000,
        S_SCAN_CHK  = 8'b0100_0000,
        S_SCAN_END  = 8'b1000_0000
    } state_t;

    // Configuration registers
    logic [ID_W-1:0] slot_count_reg;
    logic [12:0]     slot_bytes_reg;
    logic [31:0]     base_addr_reg;

    // Sequencer state
    state_t          state_reg, state_next;
    logic            boot_reg, boot_next;
    logic [IDX_W-1:0] init_cnt_reg, init_cnt_next;
    logic [ID_W-1:0] free_head_reg, free_head_next;
    logic [2:0]      op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [ID_W-1:0] cur_reg, cur_next;
    logic [ID_W-1:0] steps_reg, steps_next;
    logic [ID_W-1:0] scan_reg, scan_next;
    logic [ID_W-1:0] pend_reg, pend_next;
    logic            have_pend_reg, have_pend_next;

    // Output stage
    logic            rsp_valid_reg;
    rsp_t            rsp_data_reg;

    logic [ID_W-1:0] n_w;
    logic [ID_W-1:0] addr_sel;
    logic [31:0]     addr_calc;
    logic            emit_req;
    logic            emit_fire;
    rsp_t            emit_data;
    mem_req_t        mreq;
    logic [ID_W-1:0] link_rd;
    logic            mark_rd;
    logic [ID_W:0]   init_link;
    logic            req_fire;

    pfl_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .clk     (clk),
        .req     (mreq),
        .link_rd (link_rd),
        .mark_rd (mark_rd)
    );

    // Slots in use, clipped to the pool depth
    assign n_w = (slot_count_reg > ID_W'(SLOTS)) ? ID_W'(SLOTS) : slot_count_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    // Hold register writes off while the reset sweep or a request is in progress
    assign cfg_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign emit_fire = emit_req && (!rsp_valid_reg || rsp_ready);
    assign init_link = {1'b0, ID_W'(init_cnt_reg)} + (ID_W + 1)'(2);

    // Pick the slot whose address the current result carries
    always_comb
    begin
        if (state_reg == S_ONE && op_reg == OP_ALLOC)
        begin
            addr_sel = free_head_reg;
        end
        else if (state_reg == S_ONE)
        begin
            addr_sel = id_reg;
        end
        else
        begin
            addr_sel = pend_reg;
        end
    end

    assign addr_calc = slot_addr_f(base_addr_reg, slot_bytes_reg, addr_sel);

    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        init_cnt_next  = init_cnt_reg;
        free_head_next = free_head_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        mreq           = '0;
        emit_req       = 1'b0;
        emit_data      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Start the head link read for a possible alloc
                mreq.link_re    = 1'b1;
                mreq.link_raddr = free_head_reg - ID_W'(1);
                if (req_fire)
                begin
                    op_next = req_data.operation;
                    id_next = req_data.slot_id;
                    if (req_data.operation == OP_INIT)
                    begin
                        init_cnt_next = '0;
                        state_next    = S_INIT;
                    end
                    else if (req_data.operation == OP_ENUM)
                    begin
                        cur_next   = free_head_reg;
                        steps_next = '0;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_ONE;
                    end
                end
            end

            S_INIT:
            begin
                // Chain slot k+1 to k+2 while k+2 is in use, clear its mark
                mreq.link_we    = 1'b1;
                mreq.link_waddr = ID_W'(init_cnt_reg);
                mreq.link_wdata = (init_link <= {1'b0, n_w}) ? init_link[ID_W-1:0] : '0;
                mreq.mark_we    = 1'b1;
                mreq.mark_waddr = ID_W'(init_cnt_reg);
                mreq.mark_wdata = 1'b0;
                if (init_cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    free_head_next = (n_w != '0) ? ID_W'(1) : '0;
                    boot_next      = 1'b0;
                    state_next     = boot_reg ? S_IDLE : S_ONE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + IDX_W'(1);
                end
            end

            S_ONE:
            begin
                emit_req       = 1'b1;
                emit_data.last = 1'b1;
                unique case (op_reg)
                    OP_ALLOC:
                    begin
                        if (free_head_reg == '0 || free_head_reg > ID_W'(SLOTS))
                        begin
                            emit_data.status = ST_EMPTY;
                        end
                        else
                        begin
                            emit_data.status       = ST_OK;
                            emit_data.result_id    = free_head_reg;
                            emit_data.slot_address = addr_calc;
                            if (emit_fire)
                            begin
                                free_head_next = link_rd;
                            end
                        end
                    end
                    OP_FREE:
                    begin
                        if (id_reg == '0)
                        begin
                            emit_data.status = ST_OK;
                        end
                        else if (id_reg > n_w)
                        begin
                            emit_data.status = ST_BAD_ID;
                        end
                        else
                        begin
                            emit_data.status = ST_OK;
                            if (emit_fire)
                            begin
                                mreq.link_we    = 1'b1;
                                mreq.link_waddr = id_reg - ID_W'(1);
                                mreq.link_wdata = free_head_reg;
                                free_head_next  = id_reg;
                            end
                        end
                    end
                    OP_REF:
                    begin
                        if (id_reg == '0)
                        begin
                            emit_data.status = ST_OK;
                        end
                        else if (id_reg > n_w)
                        begin
                            emit_data.status = ST_BAD_ID;
                        end
                        else
                        begin
                            emit_data.status       = ST_OK;
                            emit_data.slot_address = addr_calc;
                        end
                    end
                    default:
                    begin
                        emit_data.status = ST_OK;
                    end
                endcase
                if (emit_fire)
                begin
                    state_next = S_IDLE;
                end
            end

            S_WALK:
            begin
                if (steps_reg == n_w || cur_reg == '0 || cur_reg > n_w)
                begin
                    scan_next      = ID_W'(1);
                    have_pend_next = 1'b0;
                    state_next     = S_SCAN;
                end
                else
                begin
                    mreq.mark_we    = 1'b1;
                    mreq.mark_waddr = cur_reg - ID_W'(1);
                    mreq.mark_wdata = 1'b1;
                    mreq.link_re    = 1'b1;
                    mreq.link_raddr = cur_reg - ID_W'(1);
                    steps_next      = steps_reg + ID_W'(1);
                    state_next      = S_WALK_WAIT;
                end
            end

            S_WALK_WAIT:
            begin
                cur_next   = link_rd;
                state_next = S_WALK;
            end

            S_SCAN:
            begin
                if (scan_reg > n_w)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    // Read the mark and clear it behind the read
                    mreq.mark_re    = 1'b1;
                    mreq.mark_raddr = scan_reg - ID_W'(1);
                    mreq.mark_we    = 1'b1;
                    mreq.mark_waddr = scan_reg - ID_W'(1);
                    mreq.mark_wdata = 1'b0;
                    state_next      = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (mark_rd)
                begin
                    scan_next  = scan_reg + ID_W'(1);
                    state_next = S_SCAN;
                end
                else if (have_pend_reg)
                begin
                    // A later live slot exists, so the held one is not last
                    emit_req               = 1'b1;
                    emit_data.status       = ST_OK;
                    emit_data.result_id    = pend_reg;
                    emit_data.slot_address = addr_calc;
                    emit_data.last         = 1'b0;
                    if (emit_fire)
                    begin
                        pend_next  = scan_reg;
                        scan_next  = scan_reg + ID_W'(1);
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    pend_next      = scan_reg;
                    have_pend_next = 1'b1;
                    scan_next      = scan_reg + ID_W'(1);
                    state_next     = S_SCAN;
                end
            end

            S_SCAN_END:
            begin
                emit_req       = 1'b1;
                emit_data.last = 1'b1;
                if (have_pend_reg)
                begin
                    emit_data.status       = ST_OK;
                    emit_data.result_id    = pend_reg;
                    emit_data.slot_address = addr_calc;
                end
                else
                begin
                    emit_data.status = ST_NO_LIVE;
                end
                if (emit_fire)
                begin
                    have_pend_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            boot_reg      <= 1'b1;
            init_cnt_reg  <= '0;
            free_head_reg <= ID_W'(1);
            op_reg        <= OP_INIT;
            id_reg        <= '0;
            cur_reg       <= '0;
            steps_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= '0;
            have_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            init_cnt_reg  <= init_cnt_next;
            free_head_reg <= free_head_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            cur_reg       <= cur_next;
            steps_reg     <= steps_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            have_pend_reg <= have_pend_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= ID_W'(64);
            slot_bytes_reg <= 13'd8;
            base_addr_reg  <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLOT_COUNT: slot_count_reg <= cfg_data[ID_W-1:0];
                CFG_SLOT_BYTES: slot_bytes_reg <= cfg_data[12:0];
                CFG_BASE_ADDR:  base_addr_reg  <= cfg_data;
                default:        slot_count_reg <= slot_count_reg;
            endcase
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            rsp_data_reg <= emit_data;
        end
    end

    `ASSERT_ALWAYS(a_head_bound, free_head_reg <= ID_W'(SLOTS), "free head beyond pool")
    `ASSERT_IMPLIES(a_walk_bound, state_reg == S_WALK_WAIT, steps_reg <= n_w, "walk overran n")
    `ASSERT_IMPLIES(a_scan_range, state_reg == S_SCAN_CHK, scan_reg != '0 && scan_reg <= n_w, "scan index out of range")
    `ASSERT_IMPLIES(a_no_stale_pend, req_fire, !have_pend_reg, "held live slot at new request")

endmodule
